// ----- hw/rtl/ghp_pkg.sv -----
// Shared types, constants and helper functions for the GRE header parser.
package ghp_pkg;

  localparam logic [15:0] PROTO_WCCP    = 16'h883E;
  localparam logic [15:0] PROTO_ERSPAN1 = 16'h88BE;
  localparam logic [15:0] PROTO_ERSPAN2 = 16'h22EB;
  localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

  // Bit positions in the GRE flags and version word
  localparam int FLAG_C_BIT = 15;
  localparam int FLAG_R_BIT = 14;
  localparam int FLAG_K_BIT = 13;
  localparam int FLAG_S_BIT = 12;
  localparam logic [15:0] FLAGS_REJECT = 16'h4007;

  // WCCPv2 probe: high nibble of the first payload byte
  localparam logic [7:0] PROBE_MASK   = 8'hF0;
  localparam logic [7:0] PROBE_WCCPV2 = 8'h40;
  localparam logic [4:0] WORD_BYTES   = 5'd4;

  // Header bytes seen, clipped; decisions never look beyond this
  localparam int AVAIL_BITS  = 6;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_TRUNCATED    = 2'd1,
    ST_BAD_VERSION  = 2'd2,
    ST_BAD_CHECKSUM = 2'd3
  } status_t;

  localparam logic REG_OUTER_PROTO   = 1'b0;
  localparam logic REG_HEADER_OFFSET = 1'b1;

  // Per-packet record handed from the byte front end to the decision stage
  typedef struct packed {
    logic [15:0]           flags;
    logic [15:0]           proto;
    logic [31:0]           key;
    logic [31:0]           seq;
    logic [15:0]           sum;
    logic [7:0]            hold;
    logic                  hold_full;
    logic [9:0]            probe;
    logic [AVAIL_BITS-1:0] avail;
  } pkt_rec_t;

  // Ones' complement add with end-around carry
  function automatic logic [15:0] sum_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'b0, t[16]};
  endfunction

  function automatic logic [4:0] base_length(input logic [15:0] f);
    return WORD_BYTES
         + (f[FLAG_C_BIT] ? WORD_BYTES : 5'd0)
         + (f[FLAG_K_BIT] ? WORD_BYTES : 5'd0)
         + (f[FLAG_S_BIT] ? WORD_BYTES : 5'd0);
  endfunction

endpackage

// ----- hw/rtl/ghp_front.sv -----
// Byte front end: tracks position, captures header words and sums the packet.
module ghp_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        header_offset,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              queue_full,
  output logic              push,
  output ghp_pkg::pkt_rec_t rec
);
  import ghp_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [15:0] flags, flags_next;
  logic [15:0] proto, proto_next;
  logic [31:0] key, key_next;
  logic [31:0] seq, seq_next;
  logic [15:0] sum, sum_next;
  logic [7:0]  hold, hold_next;
  logic        hold_full, hold_full_next;
  logic [9:0]  probe, probe_next;

  logic [POSITION_BITS-1:0] off_ext, rel, diff;
  logic [POSITION_BITS-1:0] key_at, seq_at, base_w;
  logic [4:0]               key_at_s, base;
  logic                     in_hdr, accept;
  logic [AVAIL_BITS-1:0]    avail;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last_byte;

  assign off_ext  = POSITION_BITS'(header_offset);
  assign in_hdr   = pos >= off_ext;
  assign rel      = pos - off_ext;
  assign base     = base_length(flags);
  assign key_at_s = flags[FLAG_C_BIT] ? 5'd8 : 5'd4;
  assign key_at   = POSITION_BITS'(key_at_s);
  assign seq_at   = key_at + (flags[FLAG_K_BIT] ? POSITION_BITS'(WORD_BYTES) : '0);
  assign base_w   = POSITION_BITS'(base);
  assign pos_next = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);

  always_comb begin
    flags_next     = flags;
    proto_next     = proto;
    key_next       = key;
    seq_next       = seq;
    sum_next       = sum;
    hold_next      = hold;
    hold_full_next = hold_full;
    probe_next     = probe;
    if (in_hdr) begin
      if (hold_full) begin
        sum_next       = sum_add(sum, {hold, data_byte});
        hold_full_next = 1'b0;
      end else begin
        hold_next      = data_byte;
        hold_full_next = 1'b1;
      end
      // Bytes at the saturated position feed the sum only
      if (pos != POS_MAX) begin
        if (rel < POSITION_BITS'(2)) begin
          flags_next = {flags[7:0], data_byte};
        end else if (rel < POSITION_BITS'(4)) begin
          proto_next = {proto[7:0], data_byte};
        end else begin
          if (flags[FLAG_K_BIT] && rel >= key_at
              && rel < key_at + POSITION_BITS'(WORD_BYTES)) begin
            key_next = {key[23:0], data_byte};
          end
          if (flags[FLAG_S_BIT] && rel >= seq_at
              && rel < seq_at + POSITION_BITS'(WORD_BYTES)) begin
            seq_next = {seq[23:0], data_byte};
          end
          if (proto == PROTO_WCCP) begin
            if (rel == base_w) probe_next = {2'b00, data_byte};
          end else if (rel == base_w + POSITION_BITS'(2)) begin
            probe_next = {data_byte[1:0], 8'h00};
          end else if (rel == base_w + POSITION_BITS'(3)) begin
            probe_next = probe | {2'b00, data_byte};
          end
        end
      end
    end
  end

  // Header bytes available, clipped to what the decision stage compares against
  always_comb begin
    diff = pos_next - off_ext;
    if (pos_next <= off_ext) begin
      avail = '0;
    end else if (|diff[POSITION_BITS-1:AVAIL_BITS]) begin
      avail = {AVAIL_BITS{1'b1}};
    end else begin
      avail = diff[AVAIL_BITS-1:0];
    end
  end

  always_comb begin
    rec.flags     = flags_next;
    rec.proto     = proto_next;
    rec.key       = key_next;
    rec.seq       = seq_next;
    rec.sum       = sum_next;
    rec.hold      = hold_next;
    rec.hold_full = hold_full_next;
    rec.probe     = probe_next;
    rec.avail     = avail;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      pos       <= '0;
      flags     <= '0;
      proto     <= '0;
      key       <= '0;
      seq       <= '0;
      sum       <= '0;
      hold      <= '0;
      hold_full <= 1'b0;
      probe     <= '0;
    end else if (accept) begin
      pos       <= pos_next;
      flags     <= flags_next;
      proto     <= proto_next;
      key       <= key_next;
      seq       <= seq_next;
      sum       <= sum_next;
      hold      <= hold_next;
      hold_full <= hold_full_next;
      probe     <= probe_next;
    end
  end

endmodule

// ----- hw/rtl/ghp_queue.sv -----
// Two-entry queue of packet records between the front end and the decision stage.
module ghp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ghp_pkg::pkt_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output ghp_pkg::pkt_rec_t head
);
  import ghp_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  pkt_rec_t            entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign full      = count == CNT_BITS'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_BITS'(1);
        2'b01:   count <= count - CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ghp_back.sv -----
// Decision stage: checks a finished packet record and registers the result.
module ghp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       outer_proto,
  input  logic              rec_valid,
  input  ghp_pkg::pkt_rec_t rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [15:0]       protocol,
  output logic [31:0]       gre_key,
  output logic [31:0]       sequence_res,
  output logic [4:0]        header_length,
  output logic [15:0]       flags_word
);
  import ghp_pkg::*;

  status_t     st;
  logic [15:0] final_sum, proto_r;
  logic [31:0] key_r, seq_r;
  logic [4:0]  base, hl;
  logic        erspan;

  assign pop       = rec_valid && (!out_valid || out_ready);
  assign base      = base_length(rec.flags);
  assign final_sum = rec.hold_full ? sum_add(rec.sum, {rec.hold, 8'h00}) : rec.sum;

  always_comb begin
    st      = ST_OK;
    proto_r = rec.proto;
    hl      = base;
    key_r   = rec.flags[FLAG_K_BIT] ? rec.key : 32'd0;
    seq_r   = rec.flags[FLAG_S_BIT] ? rec.seq : 32'd0;
    erspan  = 1'b0;
    if (rec.avail < AVAIL_BITS'(WORD_BYTES)) begin
      st = ST_TRUNCATED;
    end else if ((rec.flags & FLAGS_REJECT) != 16'h0000) begin
      st = ST_BAD_VERSION;
    end else if (rec.avail < AVAIL_BITS'(base)) begin
      st = ST_TRUNCATED;
    end else if (rec.flags[FLAG_C_BIT] && final_sum != SUM_GOOD) begin
      st = ST_BAD_CHECKSUM;
    end else begin
      if (rec.flags == 16'h0000 && rec.proto == PROTO_WCCP) begin
        if (rec.avail < AVAIL_BITS'(base) + AVAIL_BITS'(1)) begin
          st = ST_TRUNCATED;
        end else begin
          proto_r = outer_proto;
          // Add the redirect header unless the payload opens as WCCPv2
          if ((rec.probe[7:0] & PROBE_MASK) != PROBE_WCCPV2) hl = base + WORD_BYTES;
        end
      end
      // ERSPAN type I only counts once the header length is settled
      erspan = (rec.proto == PROTO_ERSPAN1 && hl != WORD_BYTES)
            || rec.proto == PROTO_ERSPAN2;
      if (st == ST_OK && erspan) begin
        if (rec.avail < AVAIL_BITS'(hl) + AVAIL_BITS'(WORD_BYTES)) begin
          st = ST_TRUNCATED;
        end else begin
          key_r = {22'd0, rec.probe};
        end
      end
    end
    if (st != ST_OK) begin
      proto_r = '0;
      key_r   = '0;
      seq_r   = '0;
      hl      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status        <= st;
      protocol      <= proto_r;
      gre_key       <= key_r;
      sequence_res  <= seq_r;
      header_length <= hl;
      flags_word    <= rec.flags;
    end
  end

endmodule

// ----- hw/rtl/gre_header_parser.sv -----
// GRE header parser top level: configuration registers, front end, queue, decision stage.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    data_byte, last_byte
//   out       source     out_valid/out_ready  status, protocol, gre_key, sequence_res,
//                                             header_length, flags_word
//   cfg       sink       cfg_wr_en            cfg_index, cfg_data
//
// One byte is taken per clock while in_ready is high; the front end's per-byte update
// sets that rate. The last byte's record is written into the queue, and the decision
// stage registers its result and raises out_valid when out is free.
// The two-entry queue lets the front end keep taking bytes while a result waits;
// in_ready drops only when two finished packets are queued.
// Synchronous reset clears packet state and sets outer_proto to 0x0800, offset 0.
module gre_header_parser #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] protocol,
  output logic [31:0] gre_key,
  output logic [31:0] sequence_res,
  output logic [4:0]  header_length,
  output logic [15:0] flags_word
);
  import ghp_pkg::*;

  logic [15:0] outer_proto;
  logic [7:0]  header_offset;
  logic        push, queue_full, pop, queue_valid;
  pkt_rec_t    front_rec, head_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_proto   <= 16'h0800;
      header_offset <= 8'h00;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OUTER_PROTO:   outer_proto   <= cfg_data;
        REG_HEADER_OFFSET: header_offset <= cfg_data[7:0];
      endcase
    end
  end

  ghp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .header_offset(header_offset),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .queue_full   (queue_full),
    .push         (push),
    .rec          (front_rec)
  );

  ghp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (front_rec),
    .full     (queue_full),
    .pop      (pop),
    .not_empty(queue_valid),
    .head     (head_rec)
  );

  ghp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .outer_proto  (outer_proto),
    .rec_valid    (queue_valid),
    .rec          (head_rec),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .protocol     (protocol),
    .gre_key      (gre_key),
    .sequence_res (sequence_res),
    .header_length(header_length),
    .flags_word   (flags_word)
  );

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      protocol == 16'h0000 && gre_key == 32'd0 && sequence_res == 32'd0
      && header_length == 5'd0)
    else $error("failed packet carries nonzero result fields");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |->
      header_length >= 5'd4 && header_length <= 5'd20 && header_length[1:0] == 2'b00)
    else $error("header length out of range for accepted packet");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_VERSION |-> (flags_word & FLAGS_REJECT) != 16'h0000)
    else $error("version reject without version or routing bits");

endmodule

// ----- tb/gre_header_parser_tb.sv -----
// Self-checking testbench for the GRE header parser: byte stream in, one header record out.
module gre_header_parser_tb;
  import ghp_pkg::*;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_LIMIT = '1;
  localparam logic [15:0] FLAG_C = 16'h8000;
  localparam logic [15:0] FLAG_R = 16'h4000;
  localparam logic [15:0] FLAG_K = 16'h2000;
  localparam logic [15:0] FLAG_S = 16'h1000;
  localparam logic [15:0] FLAG_VER = 16'h0007;
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    status_t     status;
    logic [15:0] protocol;
    logic [31:0] gre_key;
    logic [31:0] sequence_res;
    logic [4:0]  header_length;
    logic [15:0] flags_word;
  } gre_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_OUTER_PROTO;
  logic [15:0] cfg_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] protocol;
  logic [31:0] gre_key;
  logic [31:0] sequence_res;
  logic [4:0]  header_length;
  logic [15:0] flags_word;

  gre_header_parser #(.POSITION_BITS(POS_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .protocol(protocol),
    .gre_key(gre_key),
    .sequence_res(sequence_res),
    .header_length(header_length),
    .flags_word(flags_word)
  );

  always #10 clk = ~clk;

  // Shadow registers and per-packet parse state
  logic [15:0]         shadow_outer_proto = ETH_IPV4;
  logic [7:0]          shadow_offset = 8'h00;
  logic [POS_BITS-1:0] seen_count = '0;
  logic [15:0]         flags_acc = '0;
  logic [15:0]         proto_acc = '0;
  logic [31:0]         key_acc = '0;
  logic [31:0]         seq_acc = '0;
  logic [15:0]         sum_acc = '0;
  logic [7:0]          half_word = '0;
  logic                half_full = 1'b0;
  logic [9:0]          probe_acc = '0;

  gre_result_t expected_headers[$];
  logic [7:0]  pkt_buf[$];

  bit stall_on = 1'b1;
  int bytes_sent = 0;
  int packets_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] w);
    int unsigned t;
    t = s + w;
    t = (t & 32'h0000FFFF) + (t >> 16);
    return t[15:0];
  endfunction

  function automatic int unsigned gre_len(input logic [15:0] f);
    return 4 + (f[15] ? 4 : 0) + (f[13] ? 4 : 0) + (f[12] ? 4 : 0);
  endfunction

  function automatic void clear_parse();
    seen_count = '0;
    flags_acc = '0;
    proto_acc = '0;
    key_acc = '0;
    seq_acc = '0;
    sum_acc = '0;
    half_word = '0;
    half_full = 1'b0;
    probe_acc = '0;
  endfunction

  function automatic void take_header_byte(input int unsigned r, input logic [7:0] b);
    int unsigned key_at, seq_at, hlen;
    key_at = flags_acc[15] ? 8 : 4;
    seq_at = key_at + (flags_acc[13] ? 4 : 0);
    hlen = gre_len(flags_acc);
    if (r < 2) begin
      flags_acc = {flags_acc[7:0], b};
    end else if (r < 4) begin
      proto_acc = {proto_acc[7:0], b};
    end else begin
      if (flags_acc[13] && r >= key_at && r < key_at + 4) key_acc = {key_acc[23:0], b};
      if (flags_acc[12] && r >= seq_at && r < seq_at + 4) seq_acc = {seq_acc[23:0], b};
      if (proto_acc == PROTO_WCCP) begin
        if (r == hlen) probe_acc = {2'b00, b};
      end else if (r == hlen + 2) begin
        probe_acc = {b[1:0], 8'h00};
      end else if (r == hlen + 3) begin
        probe_acc = probe_acc | {2'b00, b};
      end
    end
  endfunction

  // Advance the parse by one byte; on the last byte queue the header record it yields
  function automatic void predict_header(input logic [7:0] b, input logic is_last);
    int unsigned total, avail, hlen, hl;
    logic [15:0] sum;
    gre_result_t res;
    if (seen_count >= shadow_offset) begin
      if (half_full) begin
        sum_acc = ones_add(sum_acc, {half_word, b});
        half_full = 1'b0;
      end else begin
        half_word = b;
        half_full = 1'b1;
      end
      if (seen_count < POS_LIMIT) take_header_byte(seen_count - shadow_offset, b);
    end
    total = (seen_count < POS_LIMIT) ? seen_count + 1 : POS_LIMIT;
    seen_count = total[POS_BITS-1:0];
    if (!is_last) return;

    avail = (total > shadow_offset) ? total - shadow_offset : 0;
    hlen = gre_len(flags_acc);
    sum = half_full ? ones_add(sum_acc, {half_word, 8'h00}) : sum_acc;
    res.status = ST_OK;
    res.protocol = '0;
    res.gre_key = '0;
    res.sequence_res = '0;
    res.header_length = '0;
    res.flags_word = flags_acc;
    if (avail < 4) begin
      res.status = ST_TRUNCATED;
    end else if ((flags_acc & (FLAG_R | FLAG_VER)) != 16'h0000) begin
      res.status = ST_BAD_VERSION;
    end else if (avail < hlen) begin
      res.status = ST_TRUNCATED;
    end else if (flags_acc[15] && sum != 16'hFFFF) begin
      res.status = ST_BAD_CHECKSUM;
    end else begin
      hl = hlen;
      res.protocol = proto_acc;
      res.gre_key = flags_acc[13] ? key_acc : 32'h0;
      res.sequence_res = flags_acc[12] ? seq_acc : 32'h0;
      if (flags_acc == 16'h0000 && proto_acc == PROTO_WCCP) begin
        if (avail < hlen + 1) begin
          res.status = ST_TRUNCATED;
        end else begin
          res.protocol = shadow_outer_proto;
          if ((probe_acc & 10'h0F0) != 10'h040) hl = hl + 4;
        end
      end
      if (res.status == ST_OK &&
          ((proto_acc == PROTO_ERSPAN1 && hl != 4) || proto_acc == PROTO_ERSPAN2)) begin
        if (avail < hl + 4) res.status = ST_TRUNCATED;
        else res.gre_key = {22'h0, probe_acc};
      end
      if (res.status == ST_OK) begin
        res.header_length = hl[4:0];
      end else begin
        res.protocol = '0;
        res.gre_key = '0;
        res.sequence_res = '0;
      end
    end
    expected_headers.push_back(res);
    clear_parse();
  endfunction

  // Result checking
  always @(posedge clk) begin
    gre_result_t exp_hdr;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_headers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: header record with nothing expected: status=%0d proto=%h flags=%h",
                   status, protocol, flags_word);
      end else begin
        exp_hdr = expected_headers.pop_front();
        status_hits[exp_hdr.status]++;
        if (status !== exp_hdr.status || protocol !== exp_hdr.protocol ||
            gre_key !== exp_hdr.gre_key || sequence_res !== exp_hdr.sequence_res ||
            header_length !== exp_hdr.header_length || flags_word !== exp_hdr.flags_word) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: record %0d exp st=%0d proto=%h key=%h seq=%h len=%0d flags=%h",
                     results_seen, exp_hdr.status, exp_hdr.protocol, exp_hdr.gre_key,
                     exp_hdr.sequence_res, exp_hdr.header_length, exp_hdr.flags_word);
            $display("       record %0d got st=%0d proto=%h key=%h seq=%h len=%0d flags=%h",
                     results_seen, status, protocol, gre_key, sequence_res,
                     header_length, flags_word);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= stall_on ? ($urandom_range(99) >= 19) : 1'b1;
  end

  // End the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (stall_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_header(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_buf.size(); i++) send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
    packets_sent++;
  endtask

  // Drop valid, wait until every record is out, then wait out the drain period
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_OUTER_PROTO) shadow_outer_proto = val;
    else shadow_offset = val[7:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] outer, input logic [7:0] offset);
    wait_idle();
    write_reg(REG_OUTER_PROTO, outer);
    write_reg(REG_HEADER_OFFSET, {8'($urandom), offset});
  endtask

  // Build prefix, GRE header and payload into pkt_buf; first payload byte is probe
  task automatic build_gre(input logic [15:0] flags, input logic [15:0] proto,
                           input logic [31:0] key, input logic [31:0] seq,
                           input int pay_len, input logic [7:0] probe, input bit good_sum);
    int base;
    logic [15:0] s;
    pkt_buf.delete();
    base = shadow_offset;
    for (int i = 0; i < base; i++) pkt_buf.push_back(8'($urandom));
    pkt_buf.push_back(flags[15:8]);
    pkt_buf.push_back(flags[7:0]);
    pkt_buf.push_back(proto[15:8]);
    pkt_buf.push_back(proto[7:0]);
    if (flags[15]) begin
      pkt_buf.push_back(8'h00);
      pkt_buf.push_back(8'h00);
      pkt_buf.push_back(8'($urandom));
      pkt_buf.push_back(8'($urandom));
    end
    if (flags[13]) for (int i = 3; i >= 0; i--) pkt_buf.push_back(key[8*i +: 8]);
    if (flags[12]) for (int i = 3; i >= 0; i--) pkt_buf.push_back(seq[8*i +: 8]);
    for (int i = 0; i < pay_len; i++) pkt_buf.push_back(i == 0 ? probe : 8'($urandom));
    if (flags[15] && good_sum) begin
      s = 16'h0000;
      for (int i = base; i < pkt_buf.size(); i += 2)
        s = ones_add(s, {pkt_buf[i], (i + 1 < pkt_buf.size()) ? pkt_buf[i + 1] : 8'h00});
      pkt_buf[base + 4] = ~s[15:8];
      pkt_buf[base + 5] = ~s[7:0];
    end
  endtask

  task automatic trim_packet(input int len);
    while (pkt_buf.size() > len) void'(pkt_buf.pop_back());
  endtask

  task automatic send_gre(input logic [15:0] flags, input logic [15:0] proto,
                          input int pay_len, input logic [7:0] probe, input bit good_sum);
    build_gre(flags, proto, $urandom, $urandom, pay_len, probe, good_sum);
    send_packet();
  endtask

  task automatic build_random_packet();
    int pick, kind;
    logic [15:0] flags, proto;
    logic [7:0] probe;
    pick = $urandom_range(99);
    kind = $urandom_range(99);
    flags = {1'($urandom), 1'b0, 1'($urandom), 1'($urandom), 12'h000};
    if (kind >= 70 && kind < 80) flags = flags | (16'($urandom) & 16'h0FF8);
    else if (kind >= 80 && kind < 90) flags = 16'($urandom);
    else if (kind >= 90) flags = 16'h0000;
    case ($urandom_range(5))
      0: proto = ETH_IPV4;
      1: proto = ETH_IPV6;
      2: proto = PROTO_WCCP;
      3: proto = PROTO_ERSPAN1;
      4: proto = PROTO_ERSPAN2;
      default: proto = 16'($urandom);
    endcase
    if (proto == PROTO_WCCP && $urandom_range(1)) flags = 16'h0000;
    probe = $urandom_range(1) ? {4'h4, 4'($urandom)} : 8'($urandom);
    build_gre(flags, proto, $urandom, $urandom, $urandom_range(12), probe,
              $urandom_range(9) != 0);
    if (pick >= 85) begin
      trim_packet($urandom_range(1, pkt_buf.size()));
    end else if (pick >= 80) begin
      pkt_buf.delete();
      repeat ($urandom_range(1, 24 + shadow_offset)) pkt_buf.push_back(8'($urandom));
    end
  endtask

  task automatic run_random_phase(input int byte_goal, input int packet_goal);
    int first_bytes, first_packets;
    first_bytes = bytes_sent;
    first_packets = packets_sent;
    while (bytes_sent - first_bytes < byte_goal || packets_sent - first_packets < packet_goal)
    begin
      build_random_packet();
      send_packet();
    end
  endtask

  task automatic test_base_header();
    send_gre(16'h0000, ETH_IPV4, 6, 8'h45, 1'b0);
    build_gre(FLAG_K | FLAG_S, 16'h0000, 32'h0, 32'h0, 2, 8'h00, 1'b0);
    send_packet();
    build_gre(FLAG_C | FLAG_K | FLAG_S, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 8'hFF, 1'b1);
    send_packet();
  endtask

  task automatic test_optional_fields();
    send_gre(FLAG_C, ETH_IPV6, 6, 8'h60, 1'b1);
    send_gre(FLAG_C, ETH_IPV6, 5, 8'h60, 1'b1);
    send_gre(FLAG_K, ETH_IPV4, 4, 8'h45, 1'b0);
    send_gre(FLAG_S, ETH_IPV4, 4, 8'h45, 1'b0);
    // corrupt one checksum bit
    build_gre(FLAG_C | FLAG_K, ETH_IPV4, $urandom, $urandom, 7, 8'h45, 1'b1);
    pkt_buf[shadow_offset + 5] = pkt_buf[shadow_offset + 5] ^ 8'h01;
    send_packet();
    send_gre(16'h0FF8, ETH_IPV4, 2, 8'h45, 1'b0);
  endtask

  task automatic test_rejects();
    send_gre(16'h0001, ETH_IPV4, 2, 8'h45, 1'b0);
    send_gre(16'h0004, ETH_IPV4, 2, 8'h45, 1'b0);
    send_gre(FLAG_R, ETH_IPV4, 2, 8'h45, 1'b0);
    send_gre(16'hFFFF, ETH_IPV4, 2, 8'h45, 1'b0);
  endtask

  task automatic test_truncation();
    build_gre(16'h0000, ETH_IPV4, 0, 0, 0, 8'h00, 1'b0);
    trim_packet(1);
    send_packet();
    build_gre(FLAG_K, ETH_IPV4, 0, 0, 0, 8'h00, 1'b0);
    trim_packet(3);
    send_packet();
    build_gre(FLAG_C | FLAG_K | FLAG_S, ETH_IPV4, $urandom, $urandom, 0, 8'h00, 1'b1);
    trim_packet(10);
    send_packet();
    send_gre(16'h0000, ETH_IPV4, 0, 8'h00, 1'b0);
  endtask

  task automatic test_wccp();
    send_gre(16'h0000, PROTO_WCCP, 4, 8'h45, 1'b0);
    send_gre(16'h0000, PROTO_WCCP, 6, 8'h00, 1'b0);
    send_gre(16'h0000, PROTO_WCCP, 0, 8'h00, 1'b0);
    send_gre(16'h0080, PROTO_WCCP, 4, 8'h00, 1'b0);
  endtask

  task automatic test_erspan();
    send_gre(FLAG_K, PROTO_ERSPAN1, 8, 8'h10, 1'b0);
    send_gre(16'h0000, PROTO_ERSPAN1, 8, 8'h10, 1'b0);
    send_gre(FLAG_S, PROTO_ERSPAN1, 3, 8'h10, 1'b0);
    send_gre(16'h0000, PROTO_ERSPAN2, 4, 8'h10, 1'b0);
    send_gre(16'h0000, PROTO_ERSPAN2, 3, 8'h10, 1'b0);
  endtask

  task automatic test_config_sweep();
    set_config(ETH_IPV6, 8'd0);
    run_random_phase(200, 5);
    set_config(16'hFFFF, 8'd255);
    send_gre(16'h0000, PROTO_WCCP, 4, 8'h00, 1'b0);
    set_config(16'h0000, 8'd1);
    send_gre(16'h0000, PROTO_WCCP, 4, 8'h4A, 1'b0);
    run_random_phase(200, 5);
    set_config(16'($urandom), 8'($urandom_range(40)));
    run_random_phase(200, 5);
  endtask

  task automatic test_no_idle();
    wait_idle();
    stall_on = 1'b0;
    run_random_phase(200, 5);
    wait_idle();
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_base_header();
    test_optional_fields();
    test_rejects();
    test_truncation();
    test_wccp();
    test_erspan();
    test_config_sweep();
    test_no_idle();
    wait_idle();
    $display("Sent %0d packets (%0d bytes) over several offset and outer protocol settings.",
             packets_sent, bytes_sent);
    $display("Checked %0d records: ok %0d, truncated %0d, version/routing %0d, checksum %0d.",
             results_seen, status_hits[ST_OK], status_hits[ST_TRUNCATED],
             status_hits[ST_BAD_VERSION], status_hits[ST_BAD_CHECKSUM]);
    if (mismatches == 0 && expected_headers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d records missing", mismatches, expected_headers.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ghp_pkg.sv
hw/rtl/ghp_front.sv
hw/rtl/ghp_queue.sv
hw/rtl/ghp_back.sv
hw/rtl/gre_header_parser.sv
tb/gre_header_parser_tb.sv
